[hdl/wfsf_pkg.sv]
// ----------------------------------------------------------------------------
// wfsf_pkg
// Shared types and constants for the wire-following steering block: modes,
// heading classes, configuration layout and register indexes.
// ----------------------------------------------------------------------------
package wfsf_pkg;

  localparam int SENSOR_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_SPEED   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOW_REVERSE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FACING_MARGIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WEAK_LEVEL     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRONG_LEVEL   = 3'd4;

  localparam logic [7:0]  FACING_MARGIN_RST = 8'd26;
  localparam logic [14:0] WEAK_LEVEL_RST    = 15'd15000;
  localparam logic [14:0] STRONG_LEVEL_RST  = 15'd26000;

  // floor(x / 10) == (x * TENTH_RECIP) >> TENTH_SHIFT for every x below 2^18
  localparam logic [16:0] TENTH_RECIP = 17'd52429;
  localparam int          TENTH_SHIFT = 19;

  localparam logic SIDE_IN  = 1'b0;
  localparam logic SIDE_OUT = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_START    = 3'd1,
    M_FINDDIR  = 3'd2,
    M_GOTOLINE = 3'd3,
    M_ALIGNING = 3'd4,
    M_TRACE    = 3'd5,
    M_DONE     = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    H_MISSING    = 4'd0,
    H_IN_NORMAL  = 4'd1,
    H_IN_LHRL    = 4'd2,
    H_IN_LLRH    = 4'd3,
    H_OUT_NORMAL = 4'd4,
    H_OUT_LHRL   = 4'd5,
    H_OUT_LLRH   = 4'd6,
    H_ALIGNED    = 4'd7,
    H_REVERSE    = 4'd8
  } head_t;

  typedef struct packed {
    logic [15:0] target_speed;
    logic        follow_reverse;
    logic [7:0]  facing_margin;
    logic [14:0] weak_level;
    logic [14:0] strong_level;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic  cmd;
    head_t head;
    logic  sl;
    logic  sr;
  } cls_t;

endpackage

[hdl/wfsf_in_if.sv]
// ----------------------------------------------------------------------------
// wfsf_in_if
// Input channel: start command or one pair of sensor readings.
// ----------------------------------------------------------------------------
interface wfsf_in_if #(
  parameter int SENSOR_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [1:0]                    left_side;
  logic [1:0]                    right_side;
  logic signed [SENSOR_BITS-1:0] left_level;
  logic signed [SENSOR_BITS-1:0] right_level;

  modport source (
    output valid, cmd, left_side, right_side, left_level, right_level,
    input  ready
  );
  modport sink (
    input  valid, cmd, left_side, right_side, left_level, right_level,
    output ready
  );
endinterface

[hdl/wfsf_out_if.sv]
// ----------------------------------------------------------------------------
// wfsf_out_if
// Result channel: drive commands, lost flag and mode after the step.
// ----------------------------------------------------------------------------
interface wfsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] turn_rate;
  logic [15:0]        forward_speed;
  logic               line_lost;
  logic [2:0]         mode_now;

  modport source (
    output valid, turn_rate, forward_speed, line_lost, mode_now,
    input  ready
  );
  modport sink (
    input  valid, turn_rate, forward_speed, line_lost, mode_now,
    output ready
  );
endinterface

[hdl/wfsf_front.sv]
// ----------------------------------------------------------------------------
// wfsf_front
// Accepts items and classifies the heading from the sensor sides and the
// relative level magnitudes.
// ----------------------------------------------------------------------------
module wfsf_front import wfsf_pkg::*; #(
  parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
  wfsf_in_if.sink                       in_if,
  input  cfg_t                          cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output cls_t                          cls,
  output logic signed [SENSOR_BITS-1:0] vl,
  output logic signed [SENSOR_BITS-1:0] vr
);

  localparam int PW = SENSOR_BITS + 9;

  logic [SENSOR_BITS-1:0] al;
  logic [SENSOR_BITS-1:0] ar;
  logic [8:0]             k;
  logic [PW-1:0]          al_256;
  logic [PW-1:0]          ar_256;
  logic [PW-1:0]          al_k;
  logic [PW-1:0]          ar_k;
  logic                   normal;
  logic                   missing;
  logic [1:0]             sl_raw;
  logic [1:0]             sr_raw;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  assign sl_raw = in_if.left_side;
  assign sr_raw = in_if.right_side;
  assign vl     = in_if.left_level;
  assign vr     = in_if.right_level;

  assign al = vl[SENSOR_BITS-1] ? (~vl + 1'b1) : vl;
  assign ar = vr[SENSOR_BITS-1] ? (~vr + 1'b1) : vr;
  assign k  = {1'b1, cfg.facing_margin};

  assign al_256 = {1'b0, al, 8'b0};
  assign ar_256 = {1'b0, ar, 8'b0};
  assign al_k   = PW'(al) * PW'(k);
  assign ar_k   = PW'(ar) * PW'(k);

  assign normal  = (al_256 < ar_k) && (ar_256 < al_k);
  assign missing = sl_raw[1] || sr_raw[1];

  always_comb begin
    cls.cmd = in_if.cmd;
    cls.sl  = sl_raw[0];
    cls.sr  = sr_raw[0];
    if (missing) begin
      cls.head = H_MISSING;
    end else if (sl_raw[0] == sr_raw[0]) begin
      if (sl_raw[0] == SIDE_IN) begin
        cls.head = normal ? H_IN_NORMAL : ((al > ar) ? H_IN_LHRL : H_IN_LLRH);
      end else begin
        cls.head = normal ? H_OUT_NORMAL : ((al > ar) ? H_OUT_LHRL : H_OUT_LLRH);
      end
    end else begin
      cls.head = (sl_raw[0] == cfg.follow_reverse) ? H_ALIGNED : H_REVERSE;
    end
  end

endmodule

[hdl/wfsf_queue.sv]
// ----------------------------------------------------------------------------
// wfsf_queue
// Short FIFO between the classifier and the mode machine.
// ----------------------------------------------------------------------------
module wfsf_queue import wfsf_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[hdl/wfsf_back.sv]
// ----------------------------------------------------------------------------
// wfsf_back
// Mode machine and drive computation, with the result register.
// ----------------------------------------------------------------------------
module wfsf_back import wfsf_pkg::*; #(
  parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          q_valid,
  input  cls_t                          cls,
  input  logic signed [SENSOR_BITS-1:0] vl,
  input  logic signed [SENSOR_BITS-1:0] vr,
  output logic                          q_pop,
  wfsf_out_if.source                    out_if
);

  localparam int CW = SENSOR_BITS + 16;

  mode_t              mode_r;
  mode_t              mode_nxt;
  logic               prev_r;
  logic               prev_nxt;
  logic [14:0]        quarter_r;
  logic [15:0]        three_q_r;
  logic [12:0]        tenth_r;
  logic [16:0]        t_plus5;
  logic [33:0]        tenth_prod;
  logic [17:0]        three_t;
  logic signed [16:0] t_s;
  logic signed [16:0] q_s;
  logic signed [16:0] tq_s;
  logic signed [16:0] te_s;
  logic signed [CW-1:0] vl_x;
  logic signed [CW-1:0] vr_x;
  logic signed [CW-1:0] weak_x;
  logic signed [CW-1:0] strong_x;
  logic               ccw;
  logic signed [16:0] turn;
  logic [15:0]        fwd;
  logic               lost;

  logic               out_valid_r;
  logic signed [16:0] turn_r;
  logic [15:0]        fwd_r;
  logic               lost_r;
  mode_t              mode_out_r;

  // drive fractions depend on the target speed only; register them
  assign t_plus5    = 17'(cfg.target_speed) + 17'd5;
  assign tenth_prod = 34'(t_plus5) * 34'(TENTH_RECIP);
  assign three_t    = 18'(cfg.target_speed) + {1'b0, cfg.target_speed, 1'b0} + 18'd2;

  always_ff @(posedge clk) begin
    quarter_r <= 15'((17'(cfg.target_speed) + 17'd2) >> 2);
    three_q_r <= three_t[17:2];
    tenth_r   <= tenth_prod[TENTH_SHIFT +: 13];
  end

  assign t_s  = $signed({1'b0, cfg.target_speed});
  assign q_s  = $signed({2'b0, quarter_r});
  assign tq_s = $signed({1'b0, three_q_r});
  assign te_s = $signed({4'b0, tenth_r});

  assign vl_x     = {{(CW - SENSOR_BITS){vl[SENSOR_BITS-1]}}, vl};
  assign vr_x     = {{(CW - SENSOR_BITS){vr[SENSOR_BITS-1]}}, vr};
  assign weak_x   = $signed({{(CW - 15){1'b0}}, cfg.weak_level});
  assign strong_x = $signed({{(CW - 15){1'b0}}, cfg.strong_level});

  assign ccw   = cls.sl ^ cfg.follow_reverse;
  assign q_pop = q_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    turn     = '0;
    fwd      = '0;
    lost     = 1'b0;
    if (!q_valid) begin
      // hold: queue empty, head entry not meaningful
    end else if (cls.cmd) begin
      mode_nxt = M_START;
    end else if (cls.head == H_MISSING) begin
      lost = 1'b1;
    end else begin
      unique case (mode_r)
        M_IDLE: begin
          mode_nxt = M_IDLE;
        end
        M_START: begin
          unique case (cls.head) inside
            H_IN_NORMAL, H_IN_LHRL, H_IN_LLRH, H_OUT_NORMAL: begin
              prev_nxt = cls.sl;
              mode_nxt = M_GOTOLINE;
            end
            H_OUT_LHRL, H_OUT_LLRH: begin
              mode_nxt = M_FINDDIR;
            end
            H_ALIGNED: begin
              mode_nxt = M_TRACE;
            end
            default: begin
              mode_nxt = M_ALIGNING;
              prev_nxt = SIDE_IN;
            end
          endcase
        end
        M_FINDDIR: begin
          if (cls.head == H_OUT_LHRL) begin
            turn = t_s;
          end else if (cls.head == H_OUT_LLRH) begin
            turn = -t_s;
          end else begin
            mode_nxt = M_START;
          end
        end
        M_GOTOLINE: begin
          if (prev_r != cls.sl || prev_r != cls.sr) begin
            mode_nxt = (cls.head == H_ALIGNED) ? M_TRACE : M_ALIGNING;
          end else begin
            if (vl > vr) begin
              turn = q_s;
            end else if (vl < vr) begin
              turn = -q_s;
            end
            fwd = cfg.target_speed;
          end
        end
        M_ALIGNING: begin
          if (cls.head == H_ALIGNED) begin
            mode_nxt = M_TRACE;
          end else begin
            turn = ccw ? t_s : -t_s;
            fwd  = 16'(quarter_r);
          end
        end
        M_TRACE: begin
          fwd = cfg.target_speed;
          if (cls.sl == cls.sr) begin
            turn = ccw ? tq_s : -tq_s;
          end else if (vl_x < weak_x) begin
            turn = q_s;
          end else if (vr_x < weak_x) begin
            turn = -q_s;
          end else if (vl_x > strong_x && vr_x > strong_x) begin
            turn = (vl < vr) ? -te_s : te_s;
          end
        end
        M_DONE: begin
          mode_nxt = M_IDLE;
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      prev_r      <= SIDE_IN;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r      <= mode_nxt;
        prev_r      <= prev_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the payload while the sink stalls
  always_ff @(posedge clk) begin
    if (q_pop) begin
      turn_r     <= turn;
      fwd_r      <= fwd;
      lost_r     <= lost;
      mode_out_r <= mode_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.turn_rate     = turn_r;
  assign out_if.forward_speed = fwd_r;
  assign out_if.line_lost     = lost_r;
  assign out_if.mode_now      = mode_out_r;

endmodule

[hdl/wire_following_steering_fsm.sv]
// ----------------------------------------------------------------------------
// wire_following_steering_fsm
// Boundary-wire following steering controller.
// ----------------------------------------------------------------------------
// Takes one item per clock: a start command or a left/right sensor pair. The
// front stage classifies the heading in the accept cycle (two narrow
// multiplies against the facing margin) and writes it into a two-entry queue;
// the back stage steps the mode machine on the queue head and registers the
// drive result, which is offered once its item has left the queue.
// Sustained rate is one item per cycle; in_if.ready drops only while the
// queue is full, which happens when the result sink stalls. Configuration
// writes land on the edge where cfg_we is high and must be made while no
// item is in flight.
// ----------------------------------------------------------------------------
module wire_following_steering_fsm import wfsf_pkg::*; #(
  parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  wfsf_in_if.sink                  in_if,
  wfsf_out_if.source               out_if,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int QW = 2 * SENSOR_BITS + $bits(cls_t);

  cfg_t                          cfg_r;
  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  cls_t                          f_cls;
  logic signed [SENSOR_BITS-1:0] f_vl;
  logic signed [SENSOR_BITS-1:0] f_vr;
  logic [QW-1:0]                 q_din;
  logic [QW-1:0]                 q_dout;
  cls_t                          b_cls;
  logic signed [SENSOR_BITS-1:0] b_vl;
  logic signed [SENSOR_BITS-1:0] b_vr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed   <= '0;
      cfg_r.follow_reverse <= 1'b0;
      cfg_r.facing_margin  <= FACING_MARGIN_RST;
      cfg_r.weak_level     <= WEAK_LEVEL_RST;
      cfg_r.strong_level   <= STRONG_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_SPEED:   cfg_r.target_speed   <= cfg_data;
        CFG_FOLLOW_REVERSE: cfg_r.follow_reverse <= cfg_data[0];
        CFG_FACING_MARGIN:  cfg_r.facing_margin  <= cfg_data[7:0];
        CFG_WEAK_LEVEL:     cfg_r.weak_level     <= cfg_data[14:0];
        CFG_STRONG_LEVEL:   cfg_r.strong_level   <= cfg_data[14:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  wfsf_front #(.SENSOR_BITS(SENSOR_BITS)) u_front (
    .in_if  (in_if),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .cls    (f_cls),
    .vl     (f_vl),
    .vr     (f_vr)
  );

  assign q_din = {f_cls, f_vl, f_vr};

  wfsf_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign b_cls = q_dout[QW-1 -: $bits(cls_t)];
  assign b_vl  = q_dout[2*SENSOR_BITS-1 -: SENSOR_BITS];
  assign b_vr  = q_dout[SENSOR_BITS-1:0];

  wfsf_back #(.SENSOR_BITS(SENSOR_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .cls     (b_cls),
    .vl      (b_vl),
    .vr      (b_vr),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

[hdl/wfsf_checker.sv]
// ----------------------------------------------------------------------------
// wfsf_checker
// Port-level checks on the result channel of the steering controller.
// ----------------------------------------------------------------------------
module wfsf_checker import wfsf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] turn_rate,
  input logic [15:0]        forward_speed,
  input logic               line_lost,
  input logic [2:0]         mode_now
);

  // a stalled result must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_lost |-> turn_rate == '0 && forward_speed == '0)
    else $error("drive given with a sensor missing");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_now == M_IDLE || mode_now == M_START)
      |-> turn_rate == '0 && forward_speed == '0)
    else $error("drive given in idle or start mode");

  a_finddir_spin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_now == M_FINDDIR |-> forward_speed == '0)
    else $error("forward drive while finding direction");

endmodule

bind wire_following_steering_fsm wfsf_checker u_wfsf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .turn_rate     (out_if.turn_rate),
  .forward_speed (out_if.forward_speed),
  .line_lost     (out_if.line_lost),
  .mode_now      (out_if.mode_now)
);

[dv/wire_following_steering_fsm_tb.sv]
// ----------------------------------------------------------------------------
// wire_following_steering_fsm_tb
// Self-checking bench for the boundary-wire steering controller. A directed
// run walks each mode up to trace and each drive case. Random start-plus-sample
// runs follow across several register settings, with random stalls on both
// channels. An in-bench model of the classifier and mode machine predicts
// every result, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module wire_following_steering_fsm_tb;
  import wfsf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 206;
  localparam int NUM_PHASES  = 9;

  typedef struct {
    logic               cmd;
    logic [1:0]         ls;
    logic [1:0]         rs;
    logic signed [15:0] lv;
    logic signed [15:0] rv;
  } sample_t;

  typedef struct {
    logic signed [16:0] turn;
    logic [15:0]        fwd;
    logic               lost;
    mode_t              mode;
  } drive_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  wfsf_in_if #(.SENSOR_BITS(16)) in_ch ();
  wfsf_out_if                    out_ch ();

  wire_following_steering_fsm #(.SENSOR_BITS(16)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror and steering state
  logic [15:0] speed_reg;
  logic        reverse_reg;
  logic [7:0]  margin_reg;
  logic [14:0] weak_reg;
  logic [14:0] strong_reg;
  mode_t       steer_mode;
  logic        entry_side;

  sample_t pending_items[$];
  drive_t  drive_due[$];
  int      idle_pct;
  int      mismatches;
  int      cycle_count;
  logic    in_fire;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic head_t classify_heading(sample_t s);
    longint lvl, rvl, al, ar, k;
    head_t  base;
    if (s.ls >= 2 || s.rs >= 2) return H_MISSING;
    if (s.ls == s.rs) begin
      lvl  = s.lv;
      rvl  = s.rv;
      al   = (lvl < 0) ? -lvl : lvl;
      ar   = (rvl < 0) ? -rvl : rvl;
      k    = 256 + longint'(margin_reg);
      base = (s.ls[0] == SIDE_IN) ? H_IN_NORMAL : H_OUT_NORMAL;
      if (al * 256 < ar * k && ar * 256 < al * k) return base;
      if (al > ar) return (base == H_IN_NORMAL) ? H_IN_LHRL : H_OUT_LHRL;
      return (base == H_IN_NORMAL) ? H_IN_LLRH : H_OUT_LLRH;
    end
    if (!reverse_reg) return (s.ls[0] == SIDE_IN) ? H_ALIGNED : H_REVERSE;
    return (s.ls[0] == SIDE_IN) ? H_REVERSE : H_ALIGNED;
  endfunction

  function automatic drive_t step_steering(sample_t s);
    drive_t r;
    head_t  h;
    longint t, q, tq, te, turn, fwd, lvl, rvl;
    logic   ccw;
    t    = longint'(speed_reg);
    q    = (t + 2) >> 2;
    tq   = (3 * t + 2) >> 2;
    te   = (t + 5) / 10;
    turn = 0;
    fwd  = 0;
    lvl  = s.lv;
    rvl  = s.rv;
    r.lost = 1'b0;
    if (s.cmd) begin
      steer_mode = M_START;
    end else begin
      h = classify_heading(s);
      if (h == H_MISSING) begin
        r.lost = 1'b1;
      end else begin
        case (steer_mode)
          M_START: begin
            if (h inside {H_IN_NORMAL, H_IN_LHRL, H_IN_LLRH, H_OUT_NORMAL}) begin
              entry_side = s.ls[0];
              steer_mode = M_GOTOLINE;
            end else if (h == H_OUT_LHRL || h == H_OUT_LLRH) begin
              steer_mode = M_FINDDIR;
            end else if (h == H_ALIGNED) begin
              steer_mode = M_TRACE;
            end else begin
              steer_mode = M_ALIGNING;
              entry_side = SIDE_IN;
            end
          end
          M_FINDDIR: begin
            if (h == H_OUT_LHRL) turn = t;
            else if (h == H_OUT_LLRH) turn = -t;
            else steer_mode = M_START;
          end
          M_GOTOLINE: begin
            if (entry_side != s.ls[0] || entry_side != s.rs[0]) begin
              steer_mode = (h == H_ALIGNED) ? M_TRACE : M_ALIGNING;
            end else begin
              if (lvl > rvl) turn = q;
              else if (lvl < rvl) turn = -q;
              fwd = t;
            end
          end
          M_ALIGNING: begin
            if (h == H_ALIGNED) begin
              steer_mode = M_TRACE;
            end else begin
              ccw  = reverse_reg ? (s.ls[0] == SIDE_IN) : (s.ls[0] == SIDE_OUT);
              turn = ccw ? t : -t;
              fwd  = q;
            end
          end
          M_TRACE: begin
            fwd = t;
            if (s.ls == s.rs) begin
              ccw  = reverse_reg ? (s.ls[0] == SIDE_IN) : (s.ls[0] == SIDE_OUT);
              turn = ccw ? tq : -tq;
            end else if (lvl < longint'(weak_reg)) begin
              turn = q;
            end else if (rvl < longint'(weak_reg)) begin
              turn = -q;
            end else if (lvl > longint'(strong_reg) && rvl > longint'(strong_reg)) begin
              turn = (lvl < rvl) ? -te : te;
            end
          end
          M_DONE: steer_mode = M_IDLE;
          default: ;
        endcase
      end
    end
    r.turn = turn[16:0];
    r.fwd  = fwd[15:0];
    r.mode = steer_mode;
    return r;
  endfunction

  function automatic sample_t mk(logic cmd, logic [1:0] ls, logic [1:0] rs,
                                 int lv, int rv);
    sample_t s;
    s.cmd = cmd;
    s.ls  = ls;
    s.rs  = rs;
    s.lv  = 16'(lv);
    s.rv  = 16'(rv);
    return s;
  endfunction

  function automatic logic [1:0] random_side();
    if ($urandom_range(99) < 8) return 2'($urandom_range(3, 2));
    return 2'($urandom_range(1));
  endfunction

  function automatic sample_t random_sample();
    int a, b, tmp;
    int extremes[5] = '{-32768, -1, 0, 1, 32767};
    case ($urandom_range(5))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        a = int'(weak_reg) + $urandom_range(600) - 300;
        b = $urandom_range(1) ? int'(weak_reg) + $urandom_range(600) - 300
                              : int'($urandom_range(32767));
      end
      2: begin
        a = int'(strong_reg) + $urandom_range(600) - 300;
        b = int'(strong_reg) + $urandom_range(600) - 300;
      end
      3: begin
        // straddle the facing margin boundary
        a = $urandom_range(16000, 1);
        b = (a * (256 + int'(margin_reg))) / 256 + $urandom_range(2) - 1;
        if ($urandom_range(1)) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end
      4: begin
        a = $urandom_range(64) - 32;
        b = $urandom_range(64) - 32;
      end
      default: begin
        a = extremes[$urandom_range(4)];
        b = extremes[$urandom_range(4)];
      end
    endcase
    return mk(1'b0, random_side(), random_side(), a, b);
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_config(logic [15:0] ts, logic fr, logic [7:0] fm,
                              logic [14:0] wl, logic [14:0] sl);
    write_reg(CFG_TARGET_SPEED, ts);
    write_reg(CFG_FOLLOW_REVERSE, {15'd0, fr});
    write_reg(CFG_FACING_MARGIN, {8'd0, fm});
    write_reg(CFG_WEAK_LEVEL, {1'b0, wl});
    write_reg(CFG_STRONG_LEVEL, {1'b0, sl});
    @(negedge clk);
    cfg_we      <= 1'b0;
    speed_reg   = ts;
    reverse_reg = fr;
    margin_reg  = fm;
    weak_reg    = wl;
    strong_reg  = sl;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || drive_due.size() != 0);
  endtask

  task automatic load_directed();
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 100, 100));       // idle sample
    pending_items.push_back(mk(1'b0, 2'd3, 2'd0, 5, 5));           // side three
    pending_items.push_back(mk(1'b1, 2'd3, 2'd2, -1, 12345));      // start
    pending_items.push_back(mk(1'b0, 2'd1, 2'd1, 30000, 100));     // to finddir
    pending_items.push_back(mk(1'b0, 2'd1, 2'd1, 30000, 100));
    pending_items.push_back(mk(1'b0, 2'd1, 2'd1, 100, 30000));
    pending_items.push_back(mk(1'b0, 2'd2, 2'd0, 0, 0));           // missing
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 5, 5));           // back to start
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, -32768, 32767));  // to gotoline
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 32767, -32768));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, -32768, 32767));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 0, 0));
    pending_items.push_back(mk(1'b0, 2'd1, 2'd0, 200, 300));       // to aligning
    pending_items.push_back(mk(1'b0, 2'd1, 2'd1, 200, 300));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 200, 300));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 200, 300));       // to trace
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 100, 20000));
    pending_items.push_back(mk(1'b0, 2'd1, 2'd0, 20000, -5));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 30000, 31000));   // strong trim
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 31000, 30000));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 30000, 30000));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd1, 20000, 20000));
    pending_items.push_back(mk(1'b0, 2'd1, 2'd1, 1, 2));
    pending_items.push_back(mk(1'b0, 2'd0, 2'd0, 1, 2));
    pending_items.push_back(mk(1'b0, 2'd3, 2'd3, -32768, 32767));
  endtask

  task automatic load_random(int count);
    int      n, k;
    sample_t s;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 15) begin
        pending_items.push_back(random_sample());
        n++;
      end else begin
        s     = random_sample();
        s.cmd = 1'b1;
        pending_items.push_back(s);
        k = $urandom_range(24, 2);
        repeat (k) pending_items.push_back(random_sample());
        n += k + 1;
      end
    end
  endtask

  // sender: hold the item until taken, then advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        automatic sample_t s = pending_items.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= s.cmd;
        in_ch.left_side   <= s.ls;
        in_ch.right_side  <= s.rs;
        in_ch.left_level  <= s.lv;
        in_ch.right_level <= s.rv;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    drive_t  want;
    sample_t s;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_due.size() == 0) begin
          $error("result with no pending item: turn_rate %0d", out_ch.turn_rate);
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          if (out_ch.turn_rate !== want.turn) begin
            $error("turn_rate: expected %0d, got %0d", want.turn, out_ch.turn_rate);
            mismatches++;
          end
          if (out_ch.forward_speed !== want.fwd) begin
            $error("forward_speed: expected %0d, got %0d", want.fwd,
                   out_ch.forward_speed);
            mismatches++;
          end
          if (out_ch.line_lost !== want.lost) begin
            $error("line_lost: expected %0d, got %0d", want.lost, out_ch.line_lost);
            mismatches++;
          end
          if (out_ch.mode_now !== want.mode) begin
            $error("mode_now: expected %0d, got %0d", want.mode, out_ch.mode_now);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.cmd = in_ch.cmd;
        s.ls  = in_ch.left_side;
        s.rs  = in_ch.right_side;
        s.lv  = in_ch.left_level;
        s.rv  = in_ch.right_level;
        drive_due.push_back(step_steering(s));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wire_following_steering_fsm verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.cmd         = 1'b0;
    in_ch.left_side   = 2'd0;
    in_ch.right_side  = 2'd0;
    in_ch.left_level  = '0;
    in_ch.right_level = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_TARGET_SPEED;
    cfg_data          = '0;
    rst_n             = 1'b0;
    in_fire           = 1'b0;
    idle_pct          = 22;
    mismatches        = 0;
    cycle_count       = 0;
    speed_reg         = '0;
    reverse_reg       = 1'b0;
    margin_reg        = FACING_MARGIN_RST;
    weak_reg          = WEAK_LEVEL_RST;
    strong_reg        = STRONG_LEVEL_RST;
    steer_mode        = M_IDLE;
    entry_side        = SIDE_IN;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      idle_pct = 22;
      case (p)
        0: apply_config(16'd1000, 1'b0, 8'd26, 15'd15000, 15'd26000);
        1: apply_config(16'hFFFF, 1'b0, 8'd26, 15'd15000, 15'd26000);
        2: apply_config(16'hFFFF, 1'b1, 8'd255, 15'h7FFF, 15'h7FFF);
        3: apply_config(16'd0, 1'b1, 8'd0, 15'd0, 15'd0);
        4: begin
          // long stretch with both channels always ready
          idle_pct = 0;
          apply_config(16'($urandom), 1'($urandom), 8'($urandom),
                       15'($urandom), 15'($urandom));
        end
        5: apply_config(16'($urandom_range(9, 1)), 1'b0, 8'd26, 15'd15000, 15'd26000);
        7: apply_config(16'd4321, 1'b1, 8'd128, 15'd15000, 15'd26000);
        default: apply_config(16'($urandom), 1'($urandom), 8'($urandom),
                              15'($urandom), 15'($urandom));
      endcase
      if (p == 0) load_directed();
      else load_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("wire_following_steering_fsm verification clean");
    end else begin
      $display("wire_following_steering_fsm verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wfsf_pkg.sv
hdl/wfsf_in_if.sv
hdl/wfsf_out_if.sv
hdl/wfsf_front.sv
hdl/wfsf_queue.sv
hdl/wfsf_back.sv
hdl/wire_following_steering_fsm.sv
hdl/wfsf_checker.sv
dv/wire_following_steering_fsm_tb.sv
